// ===== src/bda_pkg.sv =====
// ----------------------------------------------------------------------------
// bda_pkg
// Widths, constants, stage types and step functions of the brush dab alpha
// pipeline.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int unsigned MAX_DAB_DEF = 256;

    localparam int unsigned SizeW  = 9;
    localparam int unsigned PixW   = 8;
    localparam int unsigned HardW  = 9;
    localparam int unsigned AlphaW = 8;

    localparam int unsigned HardOne = 256;
    localparam logic [HardW-1:0] HardnessReset = 9'd128;
    localparam logic [AlphaW-1:0] AlphaMax = '1;

    localparam int unsigned SqW    = 2 * PixW;
    localparam int unsigned D2W    = SqW + 1;
    localparam int unsigned ProdW  = 2 * SizeW;
    localparam int unsigned RootW  = SqW;
    localparam int unsigned RadW   = 2 * RootW;
    localparam int unsigned SqRemW = RootW + 2;
    localparam int unsigned BaseW  = SizeW + 8;
    localparam int unsigned DivW   = ProdW + AlphaW;

    localparam int unsigned SqPer     = 2;
    localparam int unsigned SqStages  = RootW / SqPer;
    localparam int unsigned DivPer    = 2;
    localparam int unsigned DivStages = AlphaW / DivPer;

    typedef struct packed {
        logic             valid;
        logic             far;
        logic             full;
        logic [SizeW-1:0] size;
        logic [ProdW-1:0] hs;
        logic [ProdW-1:0] den;
    } t_side;

    typedef struct packed {
        t_side             side;
        logic [RadW-1:0]   rad;
        logic [SqRemW-1:0] rem;
        logic [RootW-1:0]  root;
    } t_sqrt;

    typedef struct packed {
        logic              valid;
        logic              far;
        logic              core;
        logic              sat;
        logic [ProdW-1:0]  den;
        logic [DivW-1:0]   rem;
        logic [AlphaW-1:0] quo;
    } t_div;

    function automatic t_sqrt sqrt_step(input t_sqrt x);
        t_sqrt             y;
        logic [SqRemW-1:0] acc;
        logic [SqRemW-1:0] trial;
        y     = x;
        acc   = {x.rem[SqRemW-3:0], x.rad[RadW-1 -: 2]};
        trial = {x.root, 2'b01};
        y.rad = {x.rad[RadW-3:0], 2'b00};
        if (acc >= trial) begin
            y.rem  = acc - trial;
            y.root = {x.root[RootW-2:0], 1'b1};
        end else begin
            y.rem  = acc;
            y.root = {x.root[RootW-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic t_div div_step(input t_div x, input int unsigned k);
        t_div            y;
        logic [DivW-1:0] sub;
        y   = x;
        sub = DivW'(x.den) << k;
        if (x.rem >= sub) begin
            y.rem = x.rem - sub;
            y.quo = x.quo | (AlphaW'(1) << k);
        end
        return y;
    endfunction

endpackage

// ===== src/brush_dab_alpha.sv =====
// ----------------------------------------------------------------------------
// brush_dab_alpha
// Alpha of one pixel of a round brush dab with a linear falloff between a hard
// core and the rim, built as a pipeline with a staged square root and divider.
// Every accepted transaction passes the registers of stages A, B and C, eight
// square root stages, stages D and E, four divider stages and the output stage.
// Throughput: one transaction per cycle; busy is low except just after reset.
// The output stage strobes each result on o_alpha_valid.
// Reset is synchronous: it empties the pipeline and sets hardness to 128.
// ----------------------------------------------------------------------------
module brush_dab_alpha #(
    parameter int unsigned MAX_DAB = bda_pkg::MAX_DAB_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [bda_pkg::SizeW-1:0]    i_dab_size,
    input  logic [bda_pkg::PixW-1:0]     i_pixel_col,
    input  logic [bda_pkg::PixW-1:0]     i_pixel_row,
    input  logic                         i_hardness_we,
    input  logic [bda_pkg::HardW-1:0]    i_hardness,
    output logic                         o_alpha_valid,
    output logic [bda_pkg::AlphaW-1:0]   o_alpha
);

    localparam int unsigned SizeW  = bda_pkg::SizeW;
    localparam int unsigned PixW   = bda_pkg::PixW;
    localparam int unsigned HardW  = bda_pkg::HardW;
    localparam int unsigned AlphaW = bda_pkg::AlphaW;
    localparam int unsigned SqW    = bda_pkg::SqW;
    localparam int unsigned D2W    = bda_pkg::D2W;
    localparam int unsigned ProdW  = bda_pkg::ProdW;
    localparam int unsigned RootW  = bda_pkg::RootW;
    localparam int unsigned BaseW  = bda_pkg::BaseW;
    localparam int unsigned DivW   = bda_pkg::DivW;
    localparam int unsigned SqStages  = bda_pkg::SqStages;
    localparam int unsigned DivStages = bda_pkg::DivStages;
    localparam int unsigned Latency   = 3 + SqStages + 2 + DivStages + 1;

    localparam int unsigned SizeTop = (1 << SizeW) - 1;
    localparam int unsigned SizeCapInt = (MAX_DAB < SizeTop) ? MAX_DAB : SizeTop;
    localparam logic [SizeW-1:0] SizeCap = SizeW'(SizeCapInt);

    logic [HardW-1:0] r_hardness;
    logic             r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hardness <= bda_pkg::HardnessReset;
            r_busy     <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_hardness_we) begin
                r_hardness <= i_hardness;
            end
        end
    end

    assign busy = r_busy;

    // Stage A: size clamp and distances from the centre.
    logic             n_a_valid;
    logic [SizeW-1:0] n_a_size;
    logic [PixW-1:0]  n_a_centre;
    logic [PixW-1:0]  n_a_dx;
    logic [PixW-1:0]  n_a_dy;
    logic             r_a_valid;
    logic [SizeW-1:0] r_a_size;
    logic [PixW-1:0]  r_a_dx;
    logic [PixW-1:0]  r_a_dy;

    always_comb begin
        n_a_valid = start && !r_busy;
        if (i_dab_size == '0) begin
            n_a_size = SizeW'(1);
        end else if (i_dab_size > SizeCap) begin
            n_a_size = SizeCap;
        end else begin
            n_a_size = i_dab_size;
        end
        n_a_centre = n_a_size[SizeW-1:1];
        n_a_dx = (i_pixel_col >= n_a_centre) ? i_pixel_col - n_a_centre
                                              : n_a_centre - i_pixel_col;
        n_a_dy = (i_pixel_row >= n_a_centre) ? i_pixel_row - n_a_centre
                                              : n_a_centre - i_pixel_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
        end
        r_a_size <= n_a_size;
        r_a_dx   <= n_a_dx;
        r_a_dy   <= n_a_dy;
    end

    // Stage B: squares and products.
    logic [HardW-1:0] n_b_soft;
    logic             r_b_valid;
    logic             r_b_full;
    logic [SizeW-1:0] r_b_size;
    logic [SqW-1:0]   r_b_dx2;
    logic [SqW-1:0]   r_b_dy2;
    logic [ProdW-1:0] r_b_ss;
    logic [ProdW-1:0] r_b_hs;
    logic [ProdW-1:0] r_b_den;

    assign n_b_soft = HardW'(bda_pkg::HardOne) - r_hardness;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_full <= (r_hardness >= HardW'(bda_pkg::HardOne));
        r_b_size <= r_a_size;
        r_b_dx2  <= SqW'(r_a_dx) * SqW'(r_a_dx);
        r_b_dy2  <= SqW'(r_a_dy) * SqW'(r_a_dy);
        r_b_ss   <= ProdW'(r_a_size) * ProdW'(r_a_size);
        r_b_hs   <= ProdW'(r_a_size) * ProdW'(r_hardness);
        r_b_den  <= ProdW'(r_a_size) * ProdW'(n_b_soft);
    end

    // Stage C: squared distance and rim test; loads the square root.
    logic [D2W-1:0]   n_c_d2;
    bda_pkg::t_sqrt   n_c;
    bda_pkg::t_sqrt   r_c;

    always_comb begin
        n_c_d2 = D2W'(r_b_dx2) + D2W'(r_b_dy2);
        n_c.side.valid = r_b_valid;
        n_c.side.far   = ({n_c_d2, 2'b00} >= (D2W + 2)'(r_b_ss));
        n_c.side.full  = r_b_full;
        n_c.side.size  = r_b_size;
        n_c.side.hs    = r_b_hs;
        n_c.side.den   = r_b_den;
        n_c.rad        = {n_c_d2[SqW-1:0], {SqW{1'b0}}};
        n_c.rem        = '0;
        n_c.root       = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.side.valid <= 1'b0;
        end else begin
            r_c <= n_c;
        end
    end

    // Square root stages, two root bits each.
    bda_pkg::t_sqrt r_sq [SqStages];

    for (genvar gi = 0; gi < SqStages; gi++) begin : g_sqrt
        bda_pkg::t_sqrt n_sq;
        always_comb begin
            n_sq = (gi == 0) ? r_c : r_sq[(gi == 0) ? 0 : gi - 1];
            for (int j = 0; j < bda_pkg::SqPer; j++) begin
                n_sq = bda_pkg::sqrt_step(n_sq);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq[gi].side.valid <= 1'b0;
            end else begin
                r_sq[gi] <= n_sq;
            end
        end
    end

    // Stage D: core test and falloff numerator.
    bda_pkg::t_sqrt   w_sq_out;
    logic [BaseW-1:0] n_d_twice;
    logic [BaseW-1:0] n_d_base;
    logic [BaseW-1:0] n_d_diff;
    bda_pkg::t_div    n_d;
    bda_pkg::t_div    r_d;

    assign w_sq_out = r_sq[SqStages-1];

    always_comb begin
        n_d_twice = BaseW'({w_sq_out.root, 1'b0});
        n_d_base  = {w_sq_out.side.size, 8'h00};
        n_d_diff  = (n_d_base > n_d_twice) ? n_d_base - n_d_twice : '0;
        n_d.valid = w_sq_out.side.valid;
        n_d.far   = w_sq_out.side.far;
        n_d.core  = w_sq_out.side.full || (ProdW'(n_d_twice) < w_sq_out.side.hs);
        n_d.sat   = 1'b0;
        n_d.den   = w_sq_out.side.den;
        n_d.rem   = (DivW'(n_d_diff) << 8) - DivW'(n_d_diff);
        n_d.quo   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else begin
            r_d <= n_d;
        end
    end

    // Stage E: quotient overflow test.
    bda_pkg::t_div n_e;
    bda_pkg::t_div r_e;

    always_comb begin
        n_e     = r_d;
        n_e.sat = (r_d.rem >= (DivW'(r_d.den) << AlphaW));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else begin
            r_e <= n_e;
        end
    end

    // Divider stages, two quotient bits each.
    bda_pkg::t_div r_dv [DivStages];

    for (genvar gi = 0; gi < DivStages; gi++) begin : g_div
        bda_pkg::t_div n_dv;
        always_comb begin
            n_dv = (gi == 0) ? r_e : r_dv[(gi == 0) ? 0 : gi - 1];
            for (int j = 0; j < bda_pkg::DivPer; j++) begin
                n_dv = bda_pkg::div_step(n_dv, AlphaW - 1 - gi * bda_pkg::DivPer - j);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gi].valid <= 1'b0;
            end else begin
                r_dv[gi] <= n_dv;
            end
        end
    end

    // Output stage.
    bda_pkg::t_div     w_dv_out;
    logic [AlphaW-1:0] n_alpha;
    logic              r_out_valid;
    logic [AlphaW-1:0] r_alpha;

    assign w_dv_out = r_dv[DivStages-1];

    always_comb begin
        if (w_dv_out.far) begin
            n_alpha = '0;
        end else if (w_dv_out.core || w_dv_out.sat) begin
            n_alpha = bda_pkg::AlphaMax;
        end else begin
            n_alpha = w_dv_out.quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_dv_out.valid;
        end
        r_alpha <= n_alpha;
    end

    assign o_alpha_valid = r_out_valid;
    assign o_alpha       = r_alpha;

    a_rim_fits_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !n_c.side.far) |-> (n_c_d2[D2W-1] == 1'b0))
        else $error("Squared distance inside the rim exceeds the root input.");

    a_root_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_out.side.valid |-> (w_sq_out.rem <= (RootW + 2)'({w_sq_out.root, 1'b0})))
        else $error("Square root remainder out of range.");

    a_div_exact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dv_out.valid && !w_dv_out.sat && !w_dv_out.core) |->
            (w_dv_out.rem < DivW'(w_dv_out.den)))
        else $error("Divider remainder not below the divisor.");

    a_result_follows_transaction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_alpha_valid |-> $past(start && !busy, Latency))
        else $error("Result strobe without a matching accepted transaction.");

endmodule
